// ===== rtl/u2u8_pkg.sv =====
// shared types, constants and register indexes of the utf-16 to utf-8 encoder
package u2u8_pkg;

	localparam int MAX_DEST_SIZE_DEF = 4096;
	localparam int QUEUE_DEPTH       = 2;
	localparam int CFG_W             = 13;
	localparam int CFG_IDX_W         = 1;
	localparam int POS_W             = 12;
	localparam int IN_DATA_W         = 16;
	localparam int OUT_DATA_W        = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_SIZE  = 1'd1;

	localparam logic [CFG_W-1:0] DEST_SIZE_RESET = 13'd4096;

	localparam logic [7:0] LEAD2  = 8'hc0;
	localparam logic [7:0] LEAD3  = 8'he0;
	localparam logic [7:0] CONT   = 8'h80;
	localparam logic [5:0] CMASK  = 6'h3f;

	typedef struct packed {
		logic [15:0] unit;
		logic [1:0]  nbytes;
		logic        term;
	} job_t;

endpackage

// ===== rtl/u2u8_queue.sv =====
// small first-in first-out queue between front and back end
module u2u8_queue #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != NW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// ===== rtl/u2u8_front.sv =====
// front end: config registers, unit classification, byte count and stop logic
module u2u8_front #(
	parameter int MAX_DEST_SIZE = u2u8_pkg::MAX_DEST_SIZE_DEF,
	localparam int CW = $clog2(MAX_DEST_SIZE)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [u2u8_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [u2u8_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [u2u8_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                           s_tlast,
	output logic                           push_valid,
	input  logic                           push_ready,
	output u2u8_pkg::job_t                 push_job,
	output logic [CW-1:0]                  push_pos
);

	import u2u8_pkg::*;

	localparam int SW = (CW + 2 > CFG_W + 1) ? CW + 2 : CFG_W + 1;

	logic              big_endian_q;
	logic [CFG_W-1:0]  dest_size_q;
	logic [CW-1:0]     count_q;
	logic              halted_q;
	logic [15:0]       unit;
	logic [1:0]        need;
	logic [SW-1:0]     dsz;
	logic [SW-1:0]     limit;
	logic [SW-1:0]     sum;
	logic              stop;
	logic              accept;

	assign unit = big_endian_q ? {s_tdata[7:0], s_tdata[15:8]} : {s_tdata[15:8], s_tdata[7:0]};

	always_comb begin
		if (unit[15:7] == '0) begin
			need = 2'd1;
		end else if (unit[15:11] == '0) begin
			need = 2'd2;
		end else begin
			need = 2'd3;
		end
	end

	always_comb begin
		dsz = SW'(dest_size_q);
		if (dsz > SW'(MAX_DEST_SIZE)) begin
			limit = SW'(MAX_DEST_SIZE);
		end else if (dsz == '0) begin
			limit = SW'(1);
		end else begin
			limit = dsz;
		end
	end

	assign sum    = SW'(count_q) + SW'(need);
	assign stop   = (unit == '0) || (sum >= limit);
	assign accept = s_tvalid && s_tready;

	assign s_tready        = push_ready;
	assign push_valid      = s_tvalid && !halted_q;
	assign push_job.unit   = unit;
	assign push_job.nbytes = stop ? 2'd0 : need;
	assign push_job.term   = stop || s_tlast;
	assign push_pos        = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
			dest_size_q  <= DEST_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIG_ENDIAN: big_endian_q <= cfg_data[0];
				REG_DEST_SIZE:  dest_size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				count_q  <= '0;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				if (stop) begin
					halted_q <= 1'b1;
				end else begin
					count_q <= CW'(sum);
				end
			end
		end
	end

endmodule

// ===== rtl/u2u8_back.sv =====
// back end: expands one queued unit into utf-8 byte beats and the terminator
module u2u8_back #(
	parameter int MAX_DEST_SIZE = u2u8_pkg::MAX_DEST_SIZE_DEF,
	localparam int CW = $clog2(MAX_DEST_SIZE)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  u2u8_pkg::job_t                  pop_job,
	input  logic [CW-1:0]                   pop_pos,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [u2u8_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	output logic                            m_tuser
);

	import u2u8_pkg::*;

	localparam int PW = (CW > POS_W) ? CW : POS_W;

	job_t          cur_q;
	logic [CW-1:0] cur_pos_q;
	logic [1:0]    k_q;
	logic          cur_valid_q;
	logic          advance;
	logic          beat_last;
	logic          is_term;
	logic [7:0]    beat_byte;
	logic [CW-1:0] beat_pos;
	logic [PW-1:0] beat_pos_ext;

	logic [7:0]       out_byte_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_term_q;
	logic             out_last_q;
	logic             out_valid_q;

	assign advance      = !out_valid_q || m_tready;
	assign beat_last    = (k_q == 2'(cur_q.nbytes + {1'b0, cur_q.term} - 2'd1));
	assign is_term      = (k_q >= cur_q.nbytes);
	assign beat_pos     = cur_pos_q + CW'(k_q);
	assign beat_pos_ext = PW'(beat_pos);
	assign pop_ready    = !cur_valid_q || (advance && beat_last);

	always_comb begin
		beat_byte = 8'h00;
		if (!is_term) begin
			unique case (cur_q.nbytes)
				2'd1: beat_byte = cur_q.unit[7:0];
				2'd2: beat_byte = (k_q == 2'd0) ? (LEAD2 | {3'b000, cur_q.unit[10:6]})
				                               : (CONT | {2'b00, cur_q.unit[5:0] & CMASK});
				2'd3: begin
					unique case (k_q)
						2'd0:    beat_byte = LEAD3 | {4'h0, cur_q.unit[15:12]};
						2'd1:    beat_byte = CONT | {2'b00, cur_q.unit[11:6] & CMASK};
						default: beat_byte = CONT | {2'b00, cur_q.unit[5:0] & CMASK};
					endcase
				end
				default: beat_byte = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (pop_ready) begin
			cur_valid_q <= pop_valid;
			k_q         <= '0;
		end else if (advance) begin
			k_q <= k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cur_q     <= pop_job;
			cur_pos_q <= pop_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cur_valid_q) begin
			out_byte_q <= beat_byte;
			out_pos_q  <= beat_pos_ext[POS_W-1:0];
			out_term_q <= is_term;
			out_last_q <= beat_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_pos_q, out_byte_q};
	assign m_tlast  = out_term_q;
	assign m_tuser  = out_last_q;

endmodule

// ===== rtl/utf16_to_utf8_encoder_top.sv =====
// Converts a stream of UTF-16 code units, one byte pair per beat, into UTF-8 bytes, one byte
// per output beat, each with its buffer position, ending every string with one NUL beat that
// carries the string length. A pair is taken in every cycle while the two-entry queue between
// the classifying front end and the byte-emitting back end has room. The back end sends one
// byte beat per cycle while the output is ready, so a pair costs its UTF-8 length in beats, plus
// one for the terminator, and the output side sets the rate. A pair's first beat is offered once
// it has passed the queue and the back end's unit and output registers. Pairs after a stop give no
// beat and wait for queue room. Registers must be written only while idle; the block lacks a check.
module utf16_to_utf8_encoder_top #(
	parameter int MAX_DEST_SIZE = u2u8_pkg::MAX_DEST_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [u2u8_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [u2u8_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// first_byte [7:0], second_byte [15:8]
	input  logic [u2u8_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_byte [7:0], out_pos [19:8], zero fill [23:20]
	output logic [u2u8_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	// last
	output logic                            m_tuser
);

	import u2u8_pkg::*;

	localparam int CW = $clog2(MAX_DEST_SIZE);
	localparam int QW = $bits(job_t) + CW;

	logic          push_valid;
	logic          push_ready;
	job_t          push_job;
	logic [CW-1:0] push_pos;
	logic          pop_valid;
	logic          pop_ready;
	job_t          pop_job;
	logic [CW-1:0] pop_pos;
	logic [QW-1:0] q_in;
	logic [QW-1:0] q_out;

	u2u8_front #(
		.MAX_DEST_SIZE(MAX_DEST_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.push_pos  (push_pos)
	);

	assign q_in = {push_pos, push_job};

	u2u8_queue #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (q_in),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (q_out)
	);

	assign pop_job = q_out[$bits(job_t)-1:0];
	assign pop_pos = q_out[QW-1:$bits(job_t)];

	u2u8_back #(
		.MAX_DEST_SIZE(MAX_DEST_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job  (pop_job),
		.pop_pos  (pop_pos),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
